/* rtl/ped_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ped_pkg
// Shared types and constants of the palette error-diffusion dither.
// ----------------------------------------------------------------------------
package ped_pkg;

	localparam int DEF_PALETTE_ENTRIES = 256;
	localparam int DEF_COMPONENT_BITS  = 6;

	localparam int INDEX_BITS = 8;
	localparam int NOISE_BITS = 5;

	// brightness = (5R + 9G + 2B) >> 4
	localparam int WEIGHT_R     = 5;
	localparam int WEIGHT_G     = 9;
	localparam int WEIGHT_B     = 2;
	localparam int BRIGHT_SHIFT = 4;

	localparam int THRESHOLD  = 32;
	localparam int FULL_SCALE = 63;
	localparam int CARRY_DIV  = 3;

	typedef enum logic {
		FUNC_PIXEL     = 1'b0,
		FUNC_PAL_WRITE = 1'b1
	} func_t;

endpackage
`default_nettype wire

/* rtl/palette_error_diffusion_dither.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// palette_error_diffusion_dither
// One-bit error-diffusion dither of palette-indexed pixels.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries either a palette write
//   (func = FUNC_PAL_WRITE: color_index, red, green, blue) or a pixel
//   (func = FUNC_PIXEL: color_index, first_in_line, start_noise).
//   Output channel (out_valid/out_ready) carries one mono_pixel per pixel;
//   palette writes give no output.
//   Throughput: one item per cycle while the output is not held. The palette
//   RAM read, a brightness stage and the carry stage form a three-stage
//   pipeline; the error carry closes within the last stage, so pixels follow
//   back to back. A transferred pixel passes the stage-1, stage-2 and output
//   registers in that order before it is offered at the output.
//   A palette write is visible to any pixel transferred in a later cycle.
//   When out_ready is low the output register holds and the stages behind
//   it keep filling; in_ready drops only once every stage is occupied.
//   Reset clears the pipeline valids and the carried error. The palette is
//   not cleared: pixels must only use entries that have been written.
// ----------------------------------------------------------------------------
module palette_error_diffusion_dither #(
	parameter int PALETTE_ENTRIES = ped_pkg::DEF_PALETTE_ENTRIES,
	parameter int COMPONENT_BITS  = ped_pkg::DEF_COMPONENT_BITS
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic                               func,
	input  wire logic [ped_pkg::INDEX_BITS-1:0]     color_index,
	input  wire logic [COMPONENT_BITS-1:0]          red,
	input  wire logic [COMPONENT_BITS-1:0]          green,
	input  wire logic [COMPONENT_BITS-1:0]          blue,
	input  wire logic                               first_in_line,
	input  wire logic signed [ped_pkg::NOISE_BITS-1:0] start_noise,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic                                    mono_pixel
);

	localparam int CB  = COMPONENT_BITS;
	localparam int AW  = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
	localparam int EW  = 3 * CB;
	localparam int PW  = CB + 5;          // weighted sum width
	localparam int SW  = CB + 3;          // signed error/sum width
	// reciprocal of 3, exact for magnitudes below 2**(SW-1)
	localparam int DS  = SW;
	localparam int DM  = ((1 << DS) + 2) / ped_pkg::CARRY_DIV;

	// ---------------------------------------------------------------- control
	logic in_xfer, pix_xfer, wr_xfer;
	logic valid_s1, valid_s2, out_valid_q;
	logic out_free, ld2, ld1;

	assign out_free = !out_valid_q || out_ready;
	assign ld2      = !valid_s2 || out_free;
	assign ld1      = !valid_s1 || ld2;
	assign in_ready = ld1;

	assign in_xfer  = in_valid && in_ready;
	assign pix_xfer = in_xfer && (ped_pkg::func_t'(func) == ped_pkg::FUNC_PIXEL);
	assign wr_xfer  = in_xfer && (ped_pkg::func_t'(func) == ped_pkg::FUNC_PAL_WRITE);

	logic in_range;
	assign in_range = {1'b0, color_index} < (ped_pkg::INDEX_BITS + 1)'(PALETTE_ENTRIES);

	// ---------------------------------------------------------------- palette
	logic [EW-1:0] ram_rdata;

	ped_ram #(
		.WIDTH (EW),
		.DEPTH (PALETTE_ENTRIES)
	) u_palette (
		.clk   (clk),
		.we    (wr_xfer && in_range),
		.waddr (color_index[AW-1:0]),
		.wdata ({red, green, blue}),
		.re    (pix_xfer),
		.raddr (color_index[AW-1:0]),
		.rdata (ram_rdata)
	);

	// ---------------------------------------------------------------- stage 1
	logic                                   oob_s1;
	logic                                   first_s1;
	logic signed [ped_pkg::NOISE_BITS-1:0]  noise_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ld1) begin
			valid_s1 <= pix_xfer;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_xfer) begin
			oob_s1   <= !in_range;
			first_s1 <= first_in_line;
			noise_s1 <= start_noise;
		end
	end

	logic [CB-1:0] r_s1, g_s1, b_s1;
	logic [PW-1:0] wsum_s1;
	logic [CB-1:0] bright_s1;

	assign {r_s1, g_s1, b_s1} = ram_rdata;

	always_comb begin
		wsum_s1 = PW'(r_s1) * PW'(ped_pkg::WEIGHT_R)
		        + PW'(g_s1) * PW'(ped_pkg::WEIGHT_G)
		        + PW'(b_s1) * PW'(ped_pkg::WEIGHT_B);
		bright_s1 = oob_s1 ? '0 : CB'(wsum_s1 >> ped_pkg::BRIGHT_SHIFT);
	end

	// ---------------------------------------------------------------- stage 2
	logic [CB-1:0]                          bright_s2;
	logic                                   first_s2;
	logic signed [ped_pkg::NOISE_BITS-1:0]  noise_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ld2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ld2 && valid_s1) begin
			bright_s2 <= bright_s1;
			first_s2  <= first_s1;
			noise_s2  <= noise_s1;
		end
	end

	// error carry loop
	logic signed [SW-1:0]  carry_q;
	logic signed [SW-1:0]  err_in, sum, resid, carry_nxt;
	logic        [SW-1:0]  mag;
	logic        [2*SW-1:0] prod;
	logic        [SW-1:0]  quot;
	logic                  bit_out;

	always_comb begin
		err_in  = first_s2 ? SW'(noise_s2) : carry_q;
		sum     = $signed({3'b000, bright_s2}) + err_in;
		bit_out = sum > $signed(SW'(ped_pkg::THRESHOLD));
		resid   = bit_out ? (sum - $signed(SW'(ped_pkg::FULL_SCALE))) : sum;
		mag     = resid[SW-1] ? SW'(-resid) : SW'(resid);
		prod    = (2 * SW)'(mag) * (2 * SW)'(DM);
		quot    = SW'(prod >> DS);
		carry_nxt = resid[SW-1] ? -$signed(quot) : $signed(quot);
	end

	logic adv2;
	assign adv2 = valid_s2 && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carry_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv2) begin
				carry_q <= carry_nxt;
			end
			if (out_free) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	logic mono_q;
	always_ff @(posedge clk) begin
		if (adv2) begin
			mono_q <= bit_out;
		end
	end

	assign out_valid  = out_valid_q;
	assign mono_pixel = mono_q;

	// ---------------------------------------------------------------- checks
	// palette writes never occupy the pipeline
	a_write_no_slot: assert property (@(posedge clk) disable iff (!arst_n)
		wr_xfer |=> !valid_s1)
		else $error("palette write entered the pixel pipeline");

	// every accepted pixel lands in stage 1
	a_pixel_slot: assert property (@(posedge clk) disable iff (!arst_n)
		pix_xfer |=> valid_s1)
		else $error("accepted pixel lost at stage 1");

	// a result only appears behind an occupied carry stage
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s2))
		else $error("output raised without a pixel in stage 2");

endmodule
`default_nettype wire

/* rtl/ped_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ped_ram
// Generic single-write, single-read RAM with registered read and read enable.
// ----------------------------------------------------------------------------
module ped_ram #(
	parameter int WIDTH = 18,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

/* dv/palette_error_diffusion_dither_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_error_diffusion_dither_tb
// Self-checking bench for the 1-bit palette dither. A directed table loads
// grey, black, white and primary palette entries and dithers them at the
// noise and threshold extremes. Random lines of pixels then follow, with
// palette rewrites mixed in. Each pixel is checked against its typed value if
// any, else a bench model of brightness, threshold and error carry. The run
// steps through input gaps, output back-pressure and a long output hold-off.
// ----------------------------------------------------------------------------
module palette_error_diffusion_dither_tb;

	localparam int CB            = ped_pkg::DEF_COMPONENT_BITS;
	localparam int IB            = ped_pkg::INDEX_BITS;
	localparam int NB            = ped_pkg::NOISE_BITS;
	localparam int COMP_MAX      = (1 << CB) - 1;
	localparam int N_DIRECTED    = 21;
	localparam int N_PER_PHASE   = 457;
	localparam int LONG_HOLD     = 250;
	localparam int SEND_IDLE [4] = '{0, 60, 0, 27};
	localparam int RECV_STALL[4] = '{0, 0, 60, 27};

	localparam logic signed [NB-1:0] NOISE_MIN  = {1'b1, {(NB - 1){1'b0}}};
	localparam logic signed [NB-1:0] NOISE_MAX  = {1'b0, {(NB - 1){1'b1}}};
	localparam logic signed [NB-1:0] NOISE_ZERO = '0;

	typedef struct packed {
		ped_pkg::func_t               op;
		logic [IB-1:0]                idx;
		logic [CB-1:0]                r, g, b;
		logic                         fil;
		logic signed [NB-1:0]         noise;
		logic                         known;      // pixel value typed in the table
		logic                         known_mono;
	} dither_item_t;

	logic                         clk            = 1'b0;
	logic                         arst_n         = 1'b0;
	logic                         in_valid       = 1'b0;
	logic                         in_ready;
	ped_pkg::func_t               func           = ped_pkg::FUNC_PIXEL;
	logic [IB-1:0]                color_index    = '0;
	logic [CB-1:0]                red            = '0;
	logic [CB-1:0]                green          = '0;
	logic [CB-1:0]                blue           = '0;
	logic                         first_in_line  = 1'b0;
	logic signed [NB-1:0]         start_noise    = '0;
	logic                         out_valid;
	logic                         out_ready      = 1'b0;
	logic                         mono_pixel;
	logic                         row_known      = 1'b0;
	logic                         row_known_mono = 1'b0;

	// bench-side dither state
	logic [CB-1:0] pal_r [256];
	logic [CB-1:0] pal_g [256];
	logic [CB-1:0] pal_b [256];
	int            carry_err = 0;
	logic          expected_mono_q[$];
	int            mismatch_count = 0;

	// sender view of which entries hold data
	bit            idx_loaded[256];
	int            loaded_list[$];

	int            send_idle_pct = 0;
	int            stall_pct     = 0;
	logic          hold_request  = 1'b0;
	int            hold_left     = 0;

	dither_item_t directed_rows[N_DIRECTED] = '{
		// palette: black, white, grey 32 and 33, pure red, green, blue
		'{ped_pkg::FUNC_PAL_WRITE, 8'd0,   6'd0,  6'd0,  6'd0,  1'b1, NOISE_MIN,  1'b0, 1'b0},
		'{ped_pkg::FUNC_PAL_WRITE, 8'd255, 6'd63, 6'd63, 6'd63, 1'b0, NOISE_MAX,  1'b0, 1'b0},
		'{ped_pkg::FUNC_PAL_WRITE, 8'd32,  6'd32, 6'd32, 6'd32, 1'b0, NOISE_ZERO, 1'b0, 1'b0},
		'{ped_pkg::FUNC_PAL_WRITE, 8'd33,  6'd33, 6'd33, 6'd33, 1'b0, NOISE_ZERO, 1'b0, 1'b0},
		'{ped_pkg::FUNC_PAL_WRITE, 8'd1,   6'd63, 6'd0,  6'd0,  1'b0, NOISE_ZERO, 1'b0, 1'b0},
		'{ped_pkg::FUNC_PAL_WRITE, 8'd2,   6'd0,  6'd63, 6'd0,  1'b0, NOISE_ZERO, 1'b0, 1'b0},
		'{ped_pkg::FUNC_PAL_WRITE, 8'd3,   6'd0,  6'd0,  6'd63, 1'b0, NOISE_ZERO, 1'b0, 1'b0},
		// line starts: noise extremes and the threshold either side
		'{ped_pkg::FUNC_PIXEL,     8'd0,   6'd0,  6'd0,  6'd0,  1'b1, NOISE_ZERO, 1'b1, 1'b0},
		'{ped_pkg::FUNC_PIXEL,     8'd255, 6'd0,  6'd0,  6'd0,  1'b1, NOISE_MAX,  1'b1, 1'b1},
		'{ped_pkg::FUNC_PIXEL,     8'd255, 6'd0,  6'd0,  6'd0,  1'b1, NOISE_MIN,  1'b1, 1'b1},
		'{ped_pkg::FUNC_PIXEL,     8'd0,   6'd0,  6'd0,  6'd0,  1'b1, NOISE_MIN,  1'b1, 1'b0},
		'{ped_pkg::FUNC_PIXEL,     8'd32,  6'd0,  6'd0,  6'd0,  1'b1, NOISE_ZERO, 1'b1, 1'b0},
		'{ped_pkg::FUNC_PIXEL,     8'd33,  6'd0,  6'd0,  6'd0,  1'b1, NOISE_ZERO, 1'b1, 1'b1},
		// carry at its negative limit, then ignored rgb and noise on pixels
		'{ped_pkg::FUNC_PIXEL,     8'd255, 6'd0,  6'd0,  6'd0,  1'b0, NOISE_MAX,  1'b0, 1'b0},
		'{ped_pkg::FUNC_PIXEL,     8'd0,   6'd63, 6'd63, 6'd63, 1'b0, NOISE_MIN,  1'b0, 1'b0},
		'{ped_pkg::FUNC_PIXEL,     8'd1,   6'd0,  6'd0,  6'd0,  1'b0, NOISE_ZERO, 1'b0, 1'b0},
		'{ped_pkg::FUNC_PIXEL,     8'd2,   6'd0,  6'd0,  6'd0,  1'b0, NOISE_ZERO, 1'b0, 1'b0},
		'{ped_pkg::FUNC_PIXEL,     8'd3,   6'd0,  6'd0,  6'd0,  1'b0, NOISE_ZERO, 1'b0, 1'b0},
		// rewrite used by the very next pixel
		'{ped_pkg::FUNC_PAL_WRITE, 8'd32,  6'd63, 6'd63, 6'd63, 1'b1, NOISE_MAX,  1'b0, 1'b0},
		'{ped_pkg::FUNC_PIXEL,     8'd32,  6'd0,  6'd0,  6'd0,  1'b1, NOISE_ZERO, 1'b1, 1'b1},
		'{ped_pkg::FUNC_PIXEL,     8'd0,   6'd0,  6'd0,  6'd0,  1'b1, NOISE_MAX,  1'b1, 1'b0}
	};

	palette_error_diffusion_dither u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.func         (func),
		.color_index  (color_index),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.first_in_line(first_in_line),
		.start_noise  (start_noise),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.mono_pixel   (mono_pixel)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Dithers one pixel and advances the carried error.
	function automatic logic dither_pixel(input logic [IB-1:0] idx, input logic fil,
			input logic signed [NB-1:0] noise);
		int lum;
		int level;
		int resid;
		lum = (ped_pkg::WEIGHT_R * int'(pal_r[idx]) + ped_pkg::WEIGHT_G * int'(pal_g[idx])
			+ ped_pkg::WEIGHT_B * int'(pal_b[idx])) >>> ped_pkg::BRIGHT_SHIFT;
		level = lum + (fil ? int'(noise) : carry_err);
		resid = (level > ped_pkg::THRESHOLD) ? level - ped_pkg::FULL_SCALE : level;
		// int division already truncates toward zero
		carry_err = resid / ped_pkg::CARRY_DIV;
		return level > ped_pkg::THRESHOLD;
	endfunction

	function automatic logic [CB-1:0] pick_component();
		int sel;
		sel = int'($urandom_range(3));
		if (sel == 0)
			return '0;
		if (sel == 1)
			return CB'(COMP_MAX);
		return CB'($urandom_range(COMP_MAX));
	endfunction

	task automatic note_loaded(input logic [IB-1:0] idx);
		if (!idx_loaded[idx]) begin
			idx_loaded[idx] = 1'b1;
			loaded_list.push_back(int'(idx));
		end
	endtask

	// Holds the item on the input until the transfer edge.
	task automatic offer(input dither_item_t it);
		in_valid       <= 1'b1;
		func           <= it.op;
		color_index    <= it.idx;
		red            <= it.r;
		green          <= it.g;
		blue           <= it.b;
		first_in_line  <= it.fil;
		start_noise    <= it.noise;
		row_known      <= it.known;
		row_known_mono <= it.known_mono;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// Receiver: random stalls, or a long hold-off when requested.
	always @(posedge clk) begin
		if (hold_request) begin
			hold_request = 1'b0;
			hold_left    = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Checks each output transfer, then predicts from each input transfer.
	always @(posedge clk) begin
		logic exp_mono;
		logic predicted;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_mono_q.size() == 0) begin
					$display("%0t: mono_pixel expected none, got %b", $time, mono_pixel);
					mismatch_count++;
				end else begin
					exp_mono = expected_mono_q.pop_front();
					if (mono_pixel !== exp_mono) begin
						$display("%0t: mono_pixel expected %b, got %b", $time, exp_mono,
							mono_pixel);
						mismatch_count++;
					end
				end
			end
			if (in_valid && in_ready) begin
				// all 256 indexes fit the palette, so every write lands
				if (func == ped_pkg::FUNC_PAL_WRITE) begin
					pal_r[color_index] = red;
					pal_g[color_index] = green;
					pal_b[color_index] = blue;
				end else begin
					predicted = dither_pixel(color_index, first_in_line, start_noise);
					expected_mono_q.push_back(row_known ? row_known_mono : predicted);
				end
			end
		end
	end

	initial begin
		int           phase;
		int           n;
		int           line_left;
		dither_item_t it;
		line_left = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (n = 0; n < N_DIRECTED; n++) begin
			if (directed_rows[n].op == ped_pkg::FUNC_PAL_WRITE)
				note_loaded(directed_rows[n].idx);
			offer(directed_rows[n]);
		end

		for (phase = 0; phase < 4; phase++) begin
			send_idle_pct = SEND_IDLE[phase];
			stall_pct     = RECV_STALL[phase];
			if (phase == 2) begin
				// let the pipeline run dry before the next pattern
				in_valid <= 1'b0;
				@(posedge clk);
				while (expected_mono_q.size() != 0)
					@(posedge clk);
			end
			for (n = 0; n < N_PER_PHASE; n++) begin
				// long output hold-off while input keeps coming, fills the pipe
				if (phase == 0 && n == 60)
					hold_request = 1'b1;
				while ($urandom_range(99) < send_idle_pct) begin
					in_valid <= 1'b0;
					@(posedge clk);
				end
				if ($urandom_range(99) < 12) begin
					it.op    = ped_pkg::FUNC_PAL_WRITE;
					it.idx   = IB'($urandom_range(255));
					it.r     = pick_component();
					it.g     = pick_component();
					it.b     = pick_component();
					it.fil   = 1'($urandom_range(1));
					it.noise = NB'($urandom_range(31));
					note_loaded(it.idx);
				end else begin
					it.op  = ped_pkg::FUNC_PIXEL;
					it.idx = IB'(loaded_list[$urandom_range(loaded_list.size() - 1)]);
					it.r   = CB'($urandom_range(COMP_MAX));
					it.g   = CB'($urandom_range(COMP_MAX));
					it.b   = CB'($urandom_range(COMP_MAX));
					if (line_left == 0) begin
						line_left = int'($urandom_range(48, 1));
						it.fil    = 1'b1;
					end else begin
						// odd restart mid-line
						it.fil = ($urandom_range(99) < 4);
					end
					line_left--;
					it.noise = NB'($urandom_range(31));
				end
				it.known      = 1'b0;
				it.known_mono = 1'b0;
				offer(it);
			end
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_mono_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("[palette_error_diffusion_dither] OK");
		else
			$display("[palette_error_diffusion_dither] ERROR");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("[palette_error_diffusion_dither] ERROR");
		$finish;
	end

endmodule
